// File: design/rc6vld_pkg.sv
// Shared types, constants and helper functions for the RC6 variable length decoder.
package rc6vld_pkg;

    localparam int PULSE_W     = 24;
    localparam int CODE_W      = 64;
    localparam int COUNT_W     = 7;
    localparam int UNIT_W      = 11;
    localparam int TOL_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int PROD_W      = 19;   // unit * (100 + tol) fits here
    localparam int SPAN_W      = 22;   // up to six times a product
    localparam int CMP_W       = 32;   // magnitude times 100, with headroom

    localparam int MAX_BITS_DEFAULT = 64;

    localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(444);
    localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(25);
    localparam logic [PROD_W-1:0] PROD_LO_RESET = PROD_W'(444 * (100 - 25));
    localparam logic [PROD_W-1:0] PROD_HI_RESET = PROD_W'(444 * (100 + 25));

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_TIME = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        PH_HDR_MARK  = 3'd0,
        PH_HDR_SPACE = 3'd1,
        PH_START     = 3'd2,
        PH_OPT_SPACE = 3'd3,
        PH_FIRST     = 3'd4,
        PH_SECOND    = 3'd5,
        PH_IGNORE    = 3'd6
    } t_phase;

    typedef struct packed {
        logic signed [PULSE_W-1:0] pulse_us;
        logic                      frame_end;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0]  code_word;
        logic [COUNT_W-1:0] bit_count;
        logic               status;
    } t_out_item;

    // One-unit window bounds, scaled by 100: unit*(100-tol) and unit*(100+tol)
    typedef struct packed {
        logic [PROD_W-1:0] prod_lo;
        logic [PROD_W-1:0] prod_hi;
    } t_win;

    function automatic logic [TOL_W-1:0] clamp_tol(input logic [TOL_W-1:0] tol);
        clamp_tol = (tol > TOL_W'(100)) ? TOL_W'(100) : tol;
    endfunction

    // Scale a one-unit bound by a small unit count with shifts and adds.
    function automatic logic [SPAN_W-1:0] scale_units(input logic [PROD_W-1:0] p,
                                                      input logic [2:0] k);
        logic [SPAN_W-1:0] pw;
        pw = SPAN_W'(p);
        scale_units = (k[0] ? pw : '0) + (k[1] ? (pw << 1) : '0) + (k[2] ? (pw << 2) : '0);
    endfunction

    // Tests floor(lo/100) <= mag <= floor(hi/100), i.e. mag*100 + 99 >= lo and mag*100 <= hi.
    function automatic logic in_window(input logic [CMP_W-1:0] m100,
                                       input logic [SPAN_W-1:0] lo,
                                       input logic [SPAN_W-1:0] hi);
        in_window = ((m100 + CMP_W'(99)) >= CMP_W'(lo)) && (m100 <= CMP_W'(hi));
    endfunction

endpackage

// File: design/rc6vld_cfg.sv
// Configuration registers and the precomputed tolerance window products.
module rc6vld_cfg
    import rc6vld_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [UNIT_W-1:0]    i_cfg_data,
    output t_win                 o_win
);

    logic [UNIT_W-1:0] r_unit, n_unit;
    logic [TOL_W-1:0]  r_tol, n_tol;
    logic [PROD_W-1:0] r_prod_lo, n_prod_lo;
    logic [PROD_W-1:0] r_prod_hi, n_prod_hi;
    logic [TOL_W-1:0]  tol_c;

    always_comb begin
        n_unit = r_unit;
        n_tol  = r_tol;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_UNIT_TIME: n_unit = i_cfg_data;
                REG_TOLERANCE: n_tol  = i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
        tol_c     = clamp_tol(n_tol);
        n_prod_lo = PROD_W'(n_unit) * PROD_W'(8'd100 - {1'b0, tol_c});
        n_prod_hi = PROD_W'(n_unit) * PROD_W'(8'd100 + {1'b0, tol_c});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit    <= UNIT_RESET;
            r_tol     <= TOL_RESET;
            r_prod_lo <= PROD_LO_RESET;
            r_prod_hi <= PROD_HI_RESET;
        end else if (i_cfg_we) begin
            r_unit    <= n_unit;
            r_tol     <= n_tol;
            r_prod_lo <= n_prod_lo;
            r_prod_hi <= n_prod_hi;
        end
    end

    assign o_win.prod_lo = r_prod_lo;
    assign o_win.prod_hi = r_prod_hi;

endmodule

// File: design/rc6vld_decode.sv
// Frame state machine: header check, Manchester bit decode and result build.
module rc6vld_decode
    import rc6vld_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_win      i_win,
    output logic      o_res_valid,
    output t_out_item o_res
);

    localparam logic [COUNT_W-1:0] BIT_LIMIT = COUNT_W'(MAX_BITS);

    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_bits, n_bits;
    logic [CODE_W-1:0]  r_buf, n_buf;

    logic [PULSE_W-1:0] raw, mag;
    logic               neg, pos, fe, nonzero;
    logic [CMP_W-1:0]   m100;
    logic [2:0]         k_bit, k_pair;
    logic               hit_hdr_mark, hit_hdr_space, hit_unit, hit_bit, hit_pair;

    always_comb begin
        raw     = i_item.pulse_us;
        fe      = i_item.frame_end;
        neg     = raw[PULSE_W-1];
        nonzero = (raw != '0);
        pos     = !neg && nonzero;
        mag     = neg ? (~raw + PULSE_W'(1)) : raw;
        m100    = (CMP_W'(mag) << 6) + (CMP_W'(mag) << 5) + (CMP_W'(mag) << 2);

        // 4th bit lasts two units; a merged half covers this bit and the next
        k_bit  = (r_bits == COUNT_W'(4)) ? 3'd2 : 3'd1;
        k_pair = ((r_bits == COUNT_W'(3)) || (r_bits == COUNT_W'(4))) ? 3'd3 : 3'd2;

        hit_hdr_mark  = in_window(m100, scale_units(i_win.prod_lo, 3'd6),
                                  scale_units(i_win.prod_hi, 3'd6));
        hit_hdr_space = in_window(m100, scale_units(i_win.prod_lo, 3'd2),
                                  scale_units(i_win.prod_hi, 3'd2));
        hit_unit      = in_window(m100, scale_units(i_win.prod_lo, 3'd1),
                                  scale_units(i_win.prod_hi, 3'd1));
        hit_bit       = nonzero && in_window(m100, scale_units(i_win.prod_lo, k_bit),
                                             scale_units(i_win.prod_hi, k_bit));
        hit_pair      = nonzero && in_window(m100, scale_units(i_win.prod_lo, k_pair),
                                             scale_units(i_win.prod_hi, k_pair));
    end

    always_comb begin
        logic fin, rej;
        fin = 1'b0;
        rej = 1'b0;
        n_phase = r_phase;
        n_bits  = r_bits;
        n_buf   = r_buf;
        unique case (r_phase)
            PH_HDR_MARK: begin
                n_bits = '0;
                n_buf  = '0;
                if (fe || !(pos && hit_hdr_mark)) begin
                    fin = 1'b1;
                    rej = 1'b1;
                end else begin
                    n_phase = PH_HDR_SPACE;
                end
            end
            PH_HDR_SPACE: begin
                if (fe || !(neg && hit_hdr_space)) begin
                    fin = 1'b1;
                    rej = 1'b1;
                end else begin
                    n_phase = PH_START;
                end
            end
            PH_START: begin
                if (!pos) begin
                    fin = 1'b1;
                    rej = 1'b1;
                end else if (fe) begin
                    fin = 1'b1;
                end else begin
                    n_phase = PH_OPT_SPACE;
                end
            end
            PH_OPT_SPACE: begin
                if (fe) begin
                    fin = 1'b1;
                end else if (neg && hit_unit) begin
                    n_phase = PH_FIRST;
                end else begin
                    n_buf   = {r_buf[CODE_W-2:0], pos};
                    n_bits  = r_bits + COUNT_W'(1);
                    n_phase = PH_SECOND;
                end
            end
            PH_FIRST: begin
                if (fe) begin
                    fin = 1'b1;
                end else begin
                    n_buf   = {r_buf[CODE_W-2:0], pos};
                    n_bits  = r_bits + COUNT_W'(1);
                    n_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                if (fe) begin
                    fin = 1'b1;
                end else if (hit_bit || hit_pair) begin
                    if (r_bits >= BIT_LIMIT) begin
                        fin = 1'b1;
                    end else if (hit_bit) begin
                        n_phase = PH_FIRST;
                    end else begin
                        // merged length doubles as the next first half
                        n_buf   = {r_buf[CODE_W-2:0], pos};
                        n_bits  = r_bits + COUNT_W'(1);
                        n_phase = PH_SECOND;
                    end
                end else begin
                    fin = 1'b1;
                    rej = 1'b1;
                end
            end
            PH_IGNORE: begin
                if (fe) begin
                    n_phase = PH_HDR_MARK;
                    n_bits  = '0;
                    n_buf   = '0;
                end
            end
            default: begin
                n_phase = PH_HDR_MARK;
                n_bits  = '0;
                n_buf   = '0;
            end
        endcase

        o_res_valid     = fin;
        o_res.code_word = rej ? '0 : r_buf;
        o_res.bit_count = rej ? '0 : r_bits;
        o_res.status    = rej;
        if (fin) begin
            n_buf   = '0;
            n_bits  = '0;
            n_phase = fe ? PH_HDR_MARK : PH_IGNORE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR_MARK;
            r_bits  <= '0;
            r_buf   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_buf   <= n_buf;
        end
    end

endmodule

// File: design/rc6_variable_length_decoder.sv
// Items wait in the input register; decoded frame results are held in the result register.
// Throughput: one item per cycle while the result side keeps up; the input register and the
// result register are the only stages, and window bounds are prepared on each config write.
// Reset (synchronous, active low): empty stages, decoder waits for a header mark,
// unit time 444 us and tolerance 25 percent.
module rc6_variable_length_decoder
    import rc6vld_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [UNIT_W-1:0]    i_cfg_data
);

    t_win      win;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      out_free, step, res_valid;
    t_out_item res;

    rc6vld_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_win       (win)
    );

    rc6vld_decode #(
        .MAX_BITS (MAX_BITS)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in_item),
        .i_win       (win),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status) |->
            (o_out_item.code_word == '0) && (o_out_item.bit_count == '0))
        else $error("rejected frame carries data");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.bit_count <= COUNT_W'(MAX_BITS)))
        else $error("bit count above limit");

    a_hold_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_item)))
        else $error("pending item lost while result side stalled");

endmodule
